>>> src/rip_relative_reference_scanner_core_macros.svh
// assertion helpers for the reference scanner checker
`ifndef RIP_RELATIVE_REFERENCE_SCANNER_CORE_MACROS_SVH
`define RIP_RELATIVE_REFERENCE_SCANNER_CORE_MACROS_SVH

// property checked outside reset
`define RRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every edge, reset included
`define RRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/rrs_pkg.sv
package rrs_pkg;

  // default address width and queue depth
  localparam int ADDR_WIDTH_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  // stream and register port widths
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 72;
  localparam int FIELD_W   = 64;
  localparam int PDATA_W   = 64;
  localparam int PADDR_W   = 4;

  // register map
  localparam logic [PADDR_W-1:0] REG_TARGET_ADDRESS = 4'h0;

  // instruction shape
  localparam int          HIST_DEPTH  = 6;
  localparam int          CAND_LEN    = 7;
  localparam logic [7:0]  REX_W_LO    = 8'h48;
  localparam logic [7:0]  REX_W_HI    = 8'h4F;
  localparam logic [7:0]  OP_LEA      = 8'h8D;
  localparam logic [7:0]  OP_MOV      = 8'h8B;
  localparam logic [7:0]  MODRM_MASK  = 8'hC7;
  localparam logic [7:0]  MODRM_RIP   = 8'h05;

  // match status codes
  localparam logic [1:0] STATUS_NONE      = 2'd0;
  localparam logic [1:0] STATUS_UNIQUE    = 2'd1;
  localparam logic [1:0] STATUS_AMBIGUOUS = 2'd2;

  // classified byte handed from front to back
  typedef struct packed {
    logic        cand;
    logic        last;
    logic [31:0] disp;
  } rrs_rec_t;

  // rex.w, lea/mov, modrm with mod 00 rm 101
  function automatic logic shape_ok(input logic [7:0] rex, input logic [7:0] op,
                                    input logic [7:0] modrm);
    logic rex_ok;
    logic op_ok;
    rex_ok = (rex >= REX_W_LO) && (rex <= REX_W_HI);
    op_ok  = (op == OP_LEA) || (op == OP_MOV);
    return rex_ok && op_ok && ((modrm & MODRM_MASK) == MODRM_RIP);
  endfunction

endpackage

>>> src/rrs_front.sv
module rrs_front #(
  parameter int ADDR_WIDTH = rrs_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            code_byte,
  input  logic [63:0]           byte_address,
  input  logic                  window_first,
  input  logic                  scan_last,
  output logic                  q_valid,
  input  logic                  q_ready,
  output rrs_pkg::rrs_rec_t     q_rec,
  output logic [ADDR_WIDTH-1:0] q_addr
);

  logic [7:0] hist [rrs_pkg::HIST_DEPTH];
  logic [2:0] fill;
  logic       take;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign take     = in_valid && q_ready;

  // classify the candidate ending at this byte
  always_comb begin
    q_rec.cand = !window_first && (fill == 3'(rrs_pkg::HIST_DEPTH)) &&
                 rrs_pkg::shape_ok(hist[0], hist[1], hist[2]);
    q_rec.last = scan_last;
    q_rec.disp = {code_byte, hist[5], hist[4], hist[3]};
    q_addr     = ADDR_WIDTH'(byte_address);
  end

  // byte history, only bytes counted by fill are ever looked at
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < rrs_pkg::HIST_DEPTH - 1; k++) begin
        hist[k] <= hist[k+1];
      end
      hist[rrs_pkg::HIST_DEPTH-1] <= code_byte;
    end
  end

  // fill count, restarted by a new window and cleared after the scan ends
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (take) begin
      priority if (scan_last) begin
        fill <= '0;
      end else if (window_first) begin
        fill <= 3'd1;
      end else if (fill != 3'(rrs_pkg::HIST_DEPTH)) begin
        fill <= fill + 3'd1;
      end
    end
  end

endmodule

>>> src/rrs_fifo.sv
module rrs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rrs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/rrs_back.sv
module rrs_back #(
  parameter int ADDR_WIDTH = rrs_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [63:0]           target_address,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  rrs_pkg::rrs_rec_t     q_rec,
  input  logic [ADDR_WIDTH-1:0] q_addr,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            match_status,
  output logic [63:0]           site_address
);

  logic [1:0]            hit_count;
  logic [ADDR_WIDTH-1:0] lead_site;
  logic [1:0]            hit_count_next;
  logic [ADDR_WIDTH-1:0] lead_site_next;
  logic [ADDR_WIDTH-1:0] target;
  logic                  hit;
  logic                  pop;

  // a scan end waits for the output register, other bytes drain freely
  assign q_ready = !q_rec.last || !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // resolve rip-relative target and count hits
  always_comb begin
    target = q_addr + ADDR_WIDTH'(1) + ADDR_WIDTH'(signed'(q_rec.disp));
    hit    = q_rec.cand && (64'(target) == target_address);
    hit_count_next = hit_count;
    lead_site_next = lead_site;
    if (hit) begin
      if (hit_count == rrs_pkg::STATUS_NONE) begin
        hit_count_next = rrs_pkg::STATUS_UNIQUE;
        lead_site_next = q_addr - ADDR_WIDTH'(rrs_pkg::CAND_LEN - 1);
      end else begin
        hit_count_next = rrs_pkg::STATUS_AMBIGUOUS;
      end
    end
  end

  // scan state, cleared once the result is taken into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count <= rrs_pkg::STATUS_NONE;
      lead_site <= '0;
    end else if (pop) begin
      if (q_rec.last) begin
        hit_count <= rrs_pkg::STATUS_NONE;
        lead_site <= '0;
      end else begin
        hit_count <= hit_count_next;
        lead_site <= lead_site_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_rec.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_rec.last) begin
      match_status <= hit_count_next;
      site_address <= (hit_count_next == rrs_pkg::STATUS_UNIQUE) ?
                      64'(lead_site_next) : '0;
    end
  end

endmodule

>>> src/rip_relative_reference_scanner_core.sv
// Scans a stream of x86-64 code bytes, one byte per cycle, for 7-byte RIP-relative lea/mov
// forms (REX.W, 8D or 8B, ModRM mod 00 rm 101, disp32) whose target equals target_address.
// Bytes are taken at one per clock for as long as the result side keeps up; a front stage
// classifies each byte against the six-byte history, a queue of QUEUE_DEPTH entries holds
// them, and a back stage does the 64-bit target add and compare and keeps the hit count.
// The result (none, unique with its site, or ambiguous) of the byte marked by s_tlast waits
// in an output register; only a scan end that meets a result held there waits in the queue.
// s_tuser marks the first byte of a window, which restarts the history. The user writes
// target_address over the APB port only while the block is idle; this is not enforced.
module rip_relative_reference_scanner_core #(
  parameter int ADDR_WIDTH  = rrs_pkg::ADDR_WIDTH_DEF,
  parameter int QUEUE_DEPTH = rrs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input bytes
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rrs_pkg::S_TDATA_W-1:0] s_tdata,  // code_byte[7:0], byte_address[71:8]
  input  logic                          s_tuser,  // window_first
  input  logic                          s_tlast,  // scan_last
  // results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rrs_pkg::M_TDATA_W-1:0] m_tdata,  // match_status[1:0], site_address[65:2],
                                                  // zero [71:66]
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrs_pkg::PADDR_W-1:0]   paddr,
  input  logic [rrs_pkg::PDATA_W-1:0]   pwdata,
  output logic [rrs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int REC_W = $bits(rrs_pkg::rrs_rec_t);
  localparam int Q_W   = REC_W + ADDR_WIDTH;

  logic [63:0]           target_address;
  logic                  f_valid;
  logic                  f_ready;
  rrs_pkg::rrs_rec_t     f_rec;
  logic [ADDR_WIDTH-1:0] f_addr;
  logic                  b_valid;
  logic                  b_ready;
  logic [Q_W-1:0]        b_data;
  rrs_pkg::rrs_rec_t     b_rec;
  logic [ADDR_WIDTH-1:0] b_addr;
  logic [1:0]            match_status;
  logic [63:0]           site_address;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == rrs_pkg::REG_TARGET_ADDRESS) ? target_address : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == rrs_pkg::REG_TARGET_ADDRESS)) begin
      target_address <= pwdata;
    end
  end

  // front: history and candidate shape
  rrs_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .code_byte    (s_tdata[7:0]),
    .byte_address (s_tdata[71:8]),
    .window_first (s_tuser),
    .scan_last    (s_tlast),
    .q_valid      (f_valid),
    .q_ready      (f_ready),
    .q_rec        (f_rec),
    .q_addr       (f_addr)
  );

  // queue between front and back
  rrs_fifo #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_rec, f_addr}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  assign b_rec  = b_data[Q_W-1:ADDR_WIDTH];
  assign b_addr = b_data[ADDR_WIDTH-1:0];

  // back: target compare, hit count and result
  rrs_back #(.ADDR_WIDTH(ADDR_WIDTH)) u_back (
    .clk            (clk),
    .rst            (rst),
    .target_address (target_address),
    .q_valid        (b_valid),
    .q_ready        (b_ready),
    .q_rec          (b_rec),
    .q_addr         (b_addr),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .match_status   (match_status),
    .site_address   (site_address)
  );

  assign m_tdata = {6'd0, site_address, match_status};

endmodule

>>> src/rrs_checker.sv
`include "rip_relative_reference_scanner_core_macros.svh"

module rrs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rrs_pkg::M_TDATA_W-1:0] m_tdata
);

  // no result is pending right after reset
  `RRS_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !m_tvalid, "result valid after reset")

  // status saturates at ambiguous
  `RRS_ASSERT(a_status_range, m_tvalid |-> (m_tdata[1:0] != 2'd3), "bad match status")

  // a site is reported only for a unique reference
  `RRS_ASSERT(a_site_zero, (m_tvalid && (m_tdata[1:0] != rrs_pkg::STATUS_UNIQUE)) |->
              (m_tdata[65:2] == 64'd0), "site set without unique match")

  // a held result keeps its value
  `RRS_ASSERT(a_result_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
              "result changed while stalled")

endmodule

bind rip_relative_reference_scanner_core rrs_checker u_rrs_checker (.*);
